[sv/epog_pkg.sv]
`timescale 1ns / 1ps

package epog_pkg;

  localparam int RatioW  = 14;
  localparam int ReadW   = 31;
  localparam int PeriodW = 16;
  localparam int WideW   = 32;
  localparam int ProdW   = ReadW + RatioW;
  localparam int NumW    = 18;
  localparam int WeightW = 10;
  localparam int OnW     = 4;
  localparam int DigitW  = 3;

  localparam int RatioDiv    = 5;
  localparam int PeriodScale = 248;

  localparam logic [RatioW-1:0]  RatioReset = RatioW'(5);
  localparam logic [PeriodW-1:0] PeriodMax  = '1;
  localparam logic [ReadW-1:0]   PendingMax = '1;
  localparam logic [OnW-1:0]     PulseTicks = OnW'(10);

  localparam logic [WeightW-1:0] WeightLow  = WeightW'(10);
  localparam logic [WeightW-1:0] WeightMid  = WeightW'(100);
  localparam logic [WeightW-1:0] WeightHigh = WeightW'(1000);

  localparam logic [NumW-1:0] NumLow  = NumW'(PeriodScale * 10);
  localparam logic [NumW-1:0] NumMid  = NumW'(PeriodScale * 100);
  localparam logic [NumW-1:0] NumHigh = NumW'(PeriodScale * 1000);

  localparam logic [RatioW-1:0] RatioLowLimit = RatioW'(11);
  localparam logic [RatioW-1:0] RatioMidLimit = RatioW'(101);

  function automatic logic [WeightW-1:0] pulse_weight(logic [RatioW-1:0] ratio);
    if (ratio < RatioLowLimit) return WeightLow;
    if (ratio < RatioMidLimit) return WeightMid;
    return WeightHigh;
  endfunction

  // Dividend of the period quotient: 248 times the pulse weight.
  function automatic logic [NumW-1:0] period_num(logic [RatioW-1:0] ratio);
    if (ratio < RatioLowLimit) return NumLow;
    if (ratio < RatioMidLimit) return NumMid;
    return NumHigh;
  endfunction

endpackage

[sv/epog_if.sv]
`timescale 1ns / 1ps

interface epog_in_if;
  logic                       valid;
  logic                       ready;
  logic                       action;
  logic [epog_pkg::ReadW-1:0] energy_reading;

  modport source (output valid, action, energy_reading, input ready);
  modport sink (input valid, action, energy_reading, output ready);
endinterface

interface epog_out_if;
  logic                         valid;
  logic                         ready;
  logic                         pulse_out;
  logic [epog_pkg::PeriodW-1:0] period_now;
  logic [epog_pkg::ReadW-1:0]   pending_energy;
  logic [epog_pkg::WideW-1:0]   total_energy;
  logic [epog_pkg::WideW-1:0]   update_count;

  modport source (output valid, pulse_out, period_now, pending_energy, total_energy,
                  update_count, input ready);
  modport sink (input valid, pulse_out, period_now, pending_energy, total_energy,
                update_count, output ready);
endinterface

[sv/epog_scale.sv]
`timescale 1ns / 1ps

// Serial scaler: diff * ratio by shift-add, one ratio bit per cycle, then
// floor division by five, one quotient bit per cycle.
module epog_scale (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [epog_pkg::ReadW-1:0]   diff_i,
  input  logic [epog_pkg::RatioW-1:0]  ratio_i,
  output logic                         done_o,
  output logic [epog_pkg::ProdW-1:0]   inc_o
);

  localparam int CntW = $clog2(epog_pkg::ProdW);
  localparam logic [CntW-1:0] MulLast = CntW'(epog_pkg::RatioW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(epog_pkg::ProdW - 1);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV} state_e;

  state_e                        state_q;
  logic [CntW-1:0]               cnt_q;
  logic                          done_q;
  logic [epog_pkg::ProdW-1:0]    acc_q;
  logic [epog_pkg::DigitW-1:0]   rem_q;
  logic [epog_pkg::RatioW-1:0]   ratio_q;
  logic [epog_pkg::ReadW-1:0]    diff_q;

  logic [epog_pkg::DigitW:0]     trial;
  logic                          qbit;
  logic [epog_pkg::ProdW-1:0]    addend;

  assign trial  = {rem_q, acc_q[epog_pkg::ProdW-1]};
  assign qbit   = trial >= (epog_pkg::DigitW + 1)'(epog_pkg::RatioDiv);
  assign addend = ratio_q[epog_pkg::RatioW-1] ? epog_pkg::ProdW'(diff_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_MUL;
            cnt_q   <= '0;
          end
        end
        S_MUL: begin
          if (cnt_q == MulLast) begin
            state_q <= S_DIV;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        S_DIV: begin
          if (cnt_q == DivLast) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          acc_q   <= '0;
          rem_q   <= '0;
          ratio_q <= ratio_i;
          diff_q  <= diff_i;
        end
      end
      S_MUL: begin
        acc_q   <= {acc_q[epog_pkg::ProdW-2:0], 1'b0} + addend;
        ratio_q <= {ratio_q[epog_pkg::RatioW-2:0], 1'b0};
      end
      S_DIV: begin
        // shift the product out at the top, the quotient in at the bottom
        rem_q <= qbit ? epog_pkg::DigitW'(trial - (epog_pkg::DigitW + 1)'(epog_pkg::RatioDiv))
                      : trial[epog_pkg::DigitW-1:0];
        acc_q <= {acc_q[epog_pkg::ProdW-2:0], qbit};
      end
      default: ;
    endcase
  end

  assign done_o = done_q;
  assign inc_o  = acc_q;

endmodule

[sv/epog_div.sv]
`timescale 1ns / 1ps

// Restoring divider for the pulse period, one quotient bit per cycle,
// quotient clamped to the period width.
module epog_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [epog_pkg::NumW-1:0]    num_i,
  input  logic [epog_pkg::ReadW-1:0]   den_i,
  output logic                         done_o,
  output logic [epog_pkg::PeriodW-1:0] quot_o
);

  localparam int CntW = $clog2(epog_pkg::NumW);
  localparam logic [CntW-1:0] RunLast = CntW'(epog_pkg::NumW - 1);

  typedef enum logic {S_IDLE, S_RUN} state_e;

  state_e                       state_q;
  logic [CntW-1:0]              cnt_q;
  logic                         done_q;
  logic [epog_pkg::NumW-1:0]    num_q;
  logic [epog_pkg::ReadW-1:0]   rem_q;
  logic [epog_pkg::ReadW-1:0]   den_q;

  logic [epog_pkg::ReadW:0]     trial;
  logic                         take;

  assign trial = {rem_q, num_q[epog_pkg::NumW-1]};
  assign take  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= S_RUN;
            cnt_q   <= '0;
          end
        end
        S_RUN: begin
          if (cnt_q == RunLast) begin
            state_q <= S_IDLE;
            done_q  <= 1'b1;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (state_q == S_RUN) begin
      rem_q <= take ? epog_pkg::ReadW'(trial - {1'b0, den_q}) : trial[epog_pkg::ReadW-1:0];
      num_q <= {num_q[epog_pkg::NumW-2:0], take};
    end
  end

  assign done_o = done_q;
  assign quot_o = (|num_q[epog_pkg::NumW-1:epog_pkg::PeriodW]) ? epog_pkg::PeriodMax
                                                               : num_q[epog_pkg::PeriodW-1:0];

endmodule

[sv/energy_pulse_output_generator.sv]
// Energy meter pulse output. Each input transfer is either a timer tick or
// an energy update; each gives exactly one result transfer with the pulse
// level, period, pending energy, total energy and update count after it.
// A tick's result is registered at the accept edge. An update runs a bit-serial
// multiply by the CT ratio, a serial divide by five and the serial period
// divider (skipped when nothing is pending), then hands off the result. One
// item is in work at a time; a new one is accepted once the block is idle
// and the output register is free. ct_ratio is written with cfg_we_i; the
// user must do so only while idle, as the block itself does not enforce it.
`timescale 1ns / 1ps

module energy_pulse_output_generator (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  epog_in_if.sink                     in_i,
  epog_out_if.source                  out_o,
  input  logic                        cfg_we_i,
  input  logic [epog_pkg::RatioW-1:0] cfg_wdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_SCALE, S_PERIOD, S_OUT} state_e;

  state_e                          state_q, state_d;
  logic [epog_pkg::RatioW-1:0]     ratio_q, ratio_d;
  logic [epog_pkg::ReadW-1:0]      last_q, last_d;
  logic [epog_pkg::ReadW-1:0]      pend_q, pend_d;
  logic [epog_pkg::PeriodW-1:0]    period_q, period_d;
  logic [epog_pkg::WideW-1:0]      timer_q, timer_d;
  logic [epog_pkg::OnW-1:0]        on_q, on_d;
  logic [epog_pkg::WideW-1:0]      total_q, total_d;
  logic [epog_pkg::WideW-1:0]      count_q, count_d;
  logic                            out_valid_q, out_valid_d;
  logic                            out_pulse_q, out_pulse_d;
  logic [epog_pkg::PeriodW-1:0]    out_period_q, out_period_d;
  logic [epog_pkg::ReadW-1:0]      out_pend_q, out_pend_d;
  logic [epog_pkg::WideW-1:0]      out_total_q, out_total_d;
  logic [epog_pkg::WideW-1:0]      out_count_q, out_count_d;
  logic [epog_pkg::ReadW-1:0]      reading_q;

  logic                            out_free;
  logic                            accept;
  logic                            load_out;
  logic [epog_pkg::WeightW-1:0]    weight;
  logic [epog_pkg::ReadW-1:0]      diff;
  logic [epog_pkg::WideW-1:0]      timer_inc;
  logic                            scale_start;
  logic                            scale_done;
  logic [epog_pkg::ProdW-1:0]      scale_inc;
  logic [epog_pkg::ProdW:0]        sum;
  logic [epog_pkg::ReadW-1:0]      pend_upd;
  logic                            div_start;
  logic                            div_done;
  logic [epog_pkg::PeriodW-1:0]    div_quot;

  assign out_free    = !out_valid_q || out_o.ready;
  assign in_i.ready  = (state_q == S_IDLE) && out_free;
  assign accept      = in_i.valid && in_i.ready;
  assign weight      = epog_pkg::pulse_weight(ratio_q);
  assign diff        = (in_i.energy_reading > last_q) ? in_i.energy_reading - last_q : '0;
  assign timer_inc   = timer_q + 1'b1;
  assign scale_start = accept && !in_i.action;
  assign sum         = (epog_pkg::ProdW + 1)'(pend_q) + (epog_pkg::ProdW + 1)'(scale_inc);
  assign pend_upd    = (|sum[epog_pkg::ProdW:epog_pkg::ReadW]) ? epog_pkg::PendingMax
                                                              : sum[epog_pkg::ReadW-1:0];
  assign div_start   = scale_done && (pend_upd != '0);

  epog_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (scale_start),
    .diff_i  (diff),
    .ratio_i (ratio_q),
    .done_o  (scale_done),
    .inc_o   (scale_inc)
  );

  epog_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (epog_pkg::period_num(ratio_q)),
    .den_i   (pend_upd),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_comb begin
    state_d      = state_q;
    ratio_d      = ratio_q;
    last_d       = last_q;
    pend_d       = pend_q;
    period_d     = period_q;
    timer_d      = timer_q;
    on_d         = on_q;
    total_d      = total_q;
    count_d      = count_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_pulse_d  = out_pulse_q;
    out_period_d = out_period_q;
    out_pend_d   = out_pend_q;
    out_total_d  = out_total_q;
    out_count_d  = out_count_q;
    load_out     = 1'b0;

    if (cfg_we_i) begin
      ratio_d = cfg_wdata_i;
    end

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (in_i.action) begin
            timer_d = timer_inc;
            if (on_q != '0) begin
              on_d = on_q - 1'b1;
            end else if (timer_inc >= epog_pkg::WideW'(period_q)) begin
              if (pend_q > epog_pkg::ReadW'(weight)) begin
                on_d   = epog_pkg::PulseTicks;
                pend_d = pend_q - epog_pkg::ReadW'(weight);
              end
              timer_d = '0;
            end
            load_out = 1'b1;
          end else begin
            state_d = S_SCALE;
          end
        end
      end
      S_SCALE: begin
        if (scale_done) begin
          last_d  = reading_q;
          pend_d  = pend_upd;
          total_d = total_q + scale_inc[epog_pkg::WideW-1:0];
          count_d = count_q + 1'b1;
          if (pend_upd == '0) begin
            period_d = epog_pkg::PeriodMax;
            state_d  = S_OUT;
          end else begin
            state_d = S_PERIOD;
          end
        end
      end
      S_PERIOD: begin
        if (div_done) begin
          period_d = div_quot;
          state_d  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (load_out) begin
      out_valid_d  = 1'b1;
      out_pulse_d  = on_d != '0;
      out_period_d = period_d;
      out_pend_d   = pend_d;
      out_total_d  = total_d;
      out_count_d  = count_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ratio_q      <= epog_pkg::RatioReset;
      last_q       <= '0;
      pend_q       <= '0;
      period_q     <= epog_pkg::PeriodMax;
      timer_q      <= '0;
      on_q         <= '0;
      total_q      <= '0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
      out_pulse_q  <= 1'b0;
      out_period_q <= '0;
      out_pend_q   <= '0;
      out_total_q  <= '0;
      out_count_q  <= '0;
    end else begin
      state_q      <= state_d;
      ratio_q      <= ratio_d;
      last_q       <= last_d;
      pend_q       <= pend_d;
      period_q     <= period_d;
      timer_q      <= timer_d;
      on_q         <= on_d;
      total_q      <= total_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
      out_pulse_q  <= out_pulse_d;
      out_period_q <= out_period_d;
      out_pend_q   <= out_pend_d;
      out_total_q  <= out_total_d;
      out_count_q  <= out_count_d;
    end
  end

  // hold the reading until the scaled increase is in
  always_ff @(posedge clk_i) begin
    if (scale_start) begin
      reading_q <= in_i.energy_reading;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.pulse_out      = out_pulse_q;
  assign out_o.period_now     = out_period_q;
  assign out_o.pending_energy = out_pend_q;
  assign out_o.total_energy   = out_total_q;
  assign out_o.update_count   = out_count_q;

  a_period_needs_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PERIOD) |-> (pend_q != '0))
    else $error("period divide running with nothing pending");

  a_pulse_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    on_q <= epog_pkg::PulseTicks)
    else $error("pulse tick count out of range");

  a_scale_done_in_scale: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scale_done |-> (state_q == S_SCALE))
    else $error("scaler finished outside an update");

  a_update_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_free) |=> (out_o.valid && state_q == S_IDLE))
    else $error("update result not presented");

endmodule
